/* src/rpf_pkg.sv */
// rpf_pkg: shared types, constants and helpers of the region peak finder
`default_nettype none
package rpf_pkg;

	// region size limit and field widths
	localparam int MAX_DIM    = 4096;
	localparam int INT_BITS   = 8;
	localparam int POS_W      = 12;
	localparam int DIM_W      = 13;
	localparam int OFF_W      = DIM_W + 1;
	localparam int SQ_W       = 24;
	localparam int DIST_W     = SQ_W + 1;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 13;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = Q_PTR_W + 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEFT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(3);

	// classified pixel handed from front to back
	typedef struct packed {
		logic [INT_BITS-1:0]    red;
		logic [DIM_W-1:0]       x;
		logic [DIM_W-1:0]       y;
		logic signed [OFF_W-1:0] dx;
		logic signed [OFF_W-1:0] dy;
		logic                   first;
		logic                   last;
	} item_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// zero counts as one, oversize saturates
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/rpf_if.sv */
// rpf_if: handshake channels of the region peak finder
`default_nettype none
interface rpf_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [rpf_pkg::INT_BITS-1:0] pixel_red;
	modport source (output valid, output pixel_red, input ready);
	modport sink (input valid, input pixel_red, output ready);
endinterface

interface rpf_peak_if;
	logic                      valid;
	logic                      ready;
	logic [rpf_pkg::DIM_W-1:0] peak_x;
	logic [rpf_pkg::DIM_W-1:0] peak_y;
	modport source (output valid, output peak_x, output peak_y, input ready);
	modport sink (input valid, input peak_x, input peak_y, output ready);
endinterface

interface rpf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rpf_pkg::CFG_IDX_W-1:0]  index;
	logic [rpf_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/rpf_front.sv */
// rpf_front: region registers, raster counters and pixel classification
`default_nettype none
module rpf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rpf_cfg_if.sink                 cfg,
	rpf_pixel_if.sink               pixel,
	input  wire rpf_pkg::q_status_t q_st,
	output rpf_pkg::item_t          item,
	output logic                    push
);

	logic [rpf_pkg::POS_W-1:0] left_q;
	logic [rpf_pkg::POS_W-1:0] top_q;
	logic [rpf_pkg::DIM_W-1:0] width_q;
	logic [rpf_pkg::DIM_W-1:0] height_q;
	logic [rpf_pkg::DIM_W-1:0] col_q;
	logic [rpf_pkg::DIM_W-1:0] row_q;
	logic [rpf_pkg::DIM_W-1:0] eff_w;
	logic [rpf_pkg::DIM_W-1:0] eff_h;
	logic                      cfg_hit;
	logic                      accept;
	logic                      last_col;
	logic                      last_row;

	// configuration is always taken
	assign cfg.ready = 1'b1;
	assign cfg_hit   = cfg.valid && (cfg.index == rpf_pkg::REG_LEFT ||
		cfg.index == rpf_pkg::REG_TOP || cfg.index == rpf_pkg::REG_WIDTH ||
		cfg.index == rpf_pkg::REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= rpf_pkg::DIM_W'(1);
			height_q <= rpf_pkg::DIM_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rpf_pkg::REG_LEFT:   left_q   <= cfg.data[rpf_pkg::POS_W-1:0];
				rpf_pkg::REG_TOP:    top_q    <= cfg.data[rpf_pkg::POS_W-1:0];
				rpf_pkg::REG_WIDTH:  width_q  <= cfg.data;
				rpf_pkg::REG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// classify the incoming pixel
	assign eff_w        = rpf_pkg::eff_dim(width_q);
	assign eff_h        = rpf_pkg::eff_dim(height_q);
	assign pixel.ready  = !q_st.full;
	assign accept       = pixel.valid && !q_st.full;
	assign push         = accept;
	assign last_col     = ({1'b0, col_q} + rpf_pkg::OFF_W'(1)) >= {1'b0, eff_w};
	assign last_row     = ({1'b0, row_q} + rpf_pkg::OFF_W'(1)) >= {1'b0, eff_h};

	always_comb begin
		item.red   = pixel.pixel_red;
		item.x     = {1'b0, left_q} + col_q;
		item.y     = {1'b0, top_q} + row_q;
		item.dx    = signed'({1'b0, col_q}) - signed'({2'b00, eff_w[rpf_pkg::DIM_W-1:1]});
		item.dy    = signed'({1'b0, row_q}) - signed'({2'b00, eff_h[rpf_pkg::DIM_W-1:1]});
		item.first = (col_q == '0) && (row_q == '0);
		item.last  = last_col && last_row;
	end

	// raster counters, cleared by a region register write or the region's end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			priority if (last_col && last_row) begin
				col_q <= '0;
				row_q <= '0;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= row_q + rpf_pkg::DIM_W'(1);
			end else begin
				col_q <= col_q + rpf_pkg::DIM_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* src/rpf_fifo.sv */
// rpf_fifo: short queue of classified pixels between front and back
`default_nettype none
module rpf_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rpf_pkg::item_t   wr_item,
	input  wire logic             pop,
	output rpf_pkg::item_t        head,
	output rpf_pkg::q_status_t    q_st
);

	rpf_pkg::item_t                mem_q [rpf_pkg::Q_DEPTH];
	logic [rpf_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [rpf_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [rpf_pkg::Q_CNT_W-1:0]   count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign q_st.full  = count_q == rpf_pkg::Q_CNT_W'(rpf_pkg::Q_DEPTH);
	assign q_st.empty = count_q == '0;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rpf_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rpf_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + rpf_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - rpf_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* src/rpf_back.sv */
// rpf_back: distance squaring, peak compare and result word register
`default_nettype none
module rpf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rpf_pkg::item_t     head,
	input  wire rpf_pkg::q_status_t q_st,
	output logic                    pop,
	rpf_peak_if.source              peak
);

	logic                           valid_s1;
	logic [rpf_pkg::INT_BITS-1:0]   red_s1;
	logic [rpf_pkg::DIM_W-1:0]      x_s1;
	logic [rpf_pkg::DIM_W-1:0]      y_s1;
	logic                           first_s1;
	logic                           last_s1;
	logic [rpf_pkg::SQ_W-1:0]       sqx_s1;
	logic [rpf_pkg::SQ_W-1:0]       sqy_s1;
	logic signed [2*rpf_pkg::OFF_W-1:0] prod_x;
	logic signed [2*rpf_pkg::OFF_W-1:0] prod_y;
	logic [rpf_pkg::INT_BITS-1:0]   best_red_q;
	logic [rpf_pkg::DIM_W-1:0]      best_x_q;
	logic [rpf_pkg::DIM_W-1:0]      best_y_q;
	logic [rpf_pkg::DIST_W-1:0]     best_dist_q;
	logic [rpf_pkg::DIST_W-1:0]     cur_dist;
	logic                           take;
	logic                           commit;
	logic                           out_valid_q;
	logic [rpf_pkg::DIM_W-1:0]      out_x_q;
	logic [rpf_pkg::DIM_W-1:0]      out_y_q;

	// squared offsets of the queue head
	assign prod_x = head.dx * head.dx;
	assign prod_y = head.dy * head.dy;

	// a final pixel waits while the result word is still unread
	assign commit = valid_s1 && !(last_s1 && out_valid_q && !peak.ready);
	assign pop    = !q_st.empty && (!valid_s1 || commit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || commit) begin
			valid_s1 <= !q_st.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			red_s1   <= head.red;
			x_s1     <= head.x;
			y_s1     <= head.y;
			first_s1 <= head.first;
			last_s1  <= head.last;
			sqx_s1   <= prod_x[rpf_pkg::SQ_W-1:0];
			sqy_s1   <= prod_y[rpf_pkg::SQ_W-1:0];
		end
	end

	// compare against the best pixel so far; the region's first pixel always loads
	assign cur_dist = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	assign take = first_s1 || (red_s1 > best_red_q) ||
		(red_s1 == best_red_q && cur_dist < best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_red_q  <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
			best_dist_q <= '0;
		end else if (commit && take) begin
			best_red_q  <= red_s1;
			best_x_q    <= x_s1;
			best_y_q    <= y_s1;
			best_dist_q <= cur_dist;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (peak.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && last_s1) begin
			out_x_q <= take ? x_s1 : best_x_q;
			out_y_q <= take ? y_s1 : best_y_q;
		end
	end

	assign peak.valid  = out_valid_q;
	assign peak.peak_x = out_x_q;
	assign peak.peak_y = out_y_q;

endmodule
`default_nettype wire

/* src/region_peak_finder_top.sv */
// region_peak_finder_top: top level of the region peak finder
//
// Peak search over a configured rectangular region. One pixel word is
// accepted per clock while the queue is not full; the front counts column
// and row and hands each pixel into a four-entry queue, the back squares the
// offsets to the region centre in one stage and updates the running peak in
// the next. The peak word is registered in an output register; only while
// that register is still unread and another final pixel reaches the compare
// stage does the back hold, and the front keeps accepting until the queue
// fills. Writing any of the four region registers restarts the search;
// write them only while no pixel is in flight.
`default_nettype none
module region_peak_finder_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rpf_cfg_if.sink     cfg,
	rpf_pixel_if.sink   pixel,
	rpf_peak_if.source  peak
);

	rpf_pkg::item_t     fr_item;
	rpf_pkg::item_t     q_head;
	rpf_pkg::q_status_t q_st;
	logic               q_push;
	logic               q_pop;

	rpf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pixel  (pixel),
		.q_st   (q_st),
		.item   (fr_item),
		.push   (q_push)
	);

	rpf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (fr_item),
		.pop     (q_pop),
		.head    (q_head),
		.q_st    (q_st)
	);

	rpf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_st   (q_st),
		.pop    (q_pop),
		.peak   (peak)
	);

`ifndef SYNTH
	// queue cannot be full and empty at once
	a_q_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_st.full && q_st.empty))
		else $error("queue full and empty together");

	// back never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_st.empty)
		else $error("pop from empty queue");

	// a full queue stays full until the back pops
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_st.full && !q_pop |=> q_st.full)
		else $error("full queue drained without pop");
`endif

endmodule
`default_nettype wire

/* bench/region_peak_finder_checker.sv */
// region_peak_finder_checker: watches the channels, predicts peak words and compares them
`default_nettype none
module region_peak_finder_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	rpf_cfg_if        cfg,
	rpf_pixel_if      pixel,
	rpf_peak_if       peak,
	output int        errors,
	output int        pending,
	output int        peaks_checked
);
	import rpf_pkg::*;

	typedef struct packed {
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
	} peak_word_t;

	// peak words predicted but not yet seen on the output
	peak_word_t expected_peaks[$];

	// mirrored region registers
	logic [POS_W-1:0] region_left;
	logic [POS_W-1:0] region_top;
	logic [DIM_W-1:0] region_width;
	logic [DIM_W-1:0] region_height;

	// running search state
	logic [DIM_W-1:0]    col_q;
	logic [DIM_W-1:0]    row_q;
	logic [INT_BITS-1:0] best_red;
	logic [DIM_W-1:0]    best_x;
	logic [DIM_W-1:0]    best_y;
	int                  best_dist;
	int                  err_cnt;
	int                  peak_cnt;

	// effective region extent: zero is one, oversize saturates
	function automatic int span(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(v);
	endfunction

	// squared distance from a pixel to the region centre
	function automatic int centre_dist(input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y);
		int cx;
		int cy;
		int dx;
		int dy;
		cx = int'(region_left) + span(region_width) / 2;
		cy = int'(region_top) + span(region_height) / 2;
		dx = int'(x) - cx;
		dy = int'(y) - cy;
		return dx * dx + dy * dy;
	endfunction

	// restart the search at the top-left pixel
	function automatic void rearm();
		col_q = '0;
		row_q = '0;
		best_red = '0;
		best_x = DIM_W'(region_left);
		best_y = DIM_W'(region_top);
		best_dist = centre_dist(best_x, best_y);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		peak_word_t       want;
		logic [DIM_W-1:0] px;
		logic [DIM_W-1:0] py;
		int               d;
		if (!arst_n) begin
			region_left = '0;
			region_top = '0;
			region_width = DIM_W'(1);
			region_height = DIM_W'(1);
			rearm();
			expected_peaks.delete();
			err_cnt = 0;
			peak_cnt = 0;
			errors <= 0;
			pending <= 0;
			peaks_checked <= 0;
		end else begin
			// register write: any known index restarts the search
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_LEFT: begin
						region_left = cfg.data[POS_W-1:0];
					end
					REG_TOP: begin
						region_top = cfg.data[POS_W-1:0];
					end
					REG_WIDTH: begin
						region_width = cfg.data;
					end
					REG_HEIGHT: begin
						region_height = cfg.data;
					end
					default: begin
					end
				endcase
				if (cfg.index == REG_LEFT || cfg.index == REG_TOP ||
						cfg.index == REG_WIDTH || cfg.index == REG_HEIGHT) begin
					rearm();
				end
			end

			// pixel word: compare against running peak, emit on final pixel
			if (pixel.valid && pixel.ready) begin
				px = DIM_W'(region_left) + col_q;
				py = DIM_W'(region_top) + row_q;
				d = centre_dist(px, py);
				if (pixel.pixel_red > best_red ||
						(pixel.pixel_red == best_red && d < best_dist)) begin
					best_red = pixel.pixel_red;
					best_x = px;
					best_y = py;
					best_dist = d;
				end
				if (int'(col_q) + 1 >= span(region_width) &&
						int'(row_q) + 1 >= span(region_height)) begin
					expected_peaks.push_back('{x: best_x, y: best_y});
					rearm();
				end else if (int'(col_q) + 1 >= span(region_width)) begin
					col_q = '0;
					row_q = row_q + 1'b1;
				end else begin
					col_q = col_q + 1'b1;
				end
			end

			// peak word: compare with the oldest prediction
			if (peak.valid && peak.ready) begin
				peak_cnt++;
				if (expected_peaks.size() == 0) begin
					err_cnt++;
					$display("%0t unexpected peak word: expected none, actual (%0d,%0d)",
						$time, peak.peak_x, peak.peak_y);
				end else begin
					want = expected_peaks.pop_front();
					if (peak.peak_x !== want.x) begin
						err_cnt++;
						$display("%0t peak_x mismatch: expected %0d, actual %0d",
							$time, want.x, peak.peak_x);
					end
					if (peak.peak_y !== want.y) begin
						err_cnt++;
						$display("%0t peak_y mismatch: expected %0d, actual %0d",
							$time, want.y, peak.peak_y);
					end
				end
			end

			errors <= err_cnt;
			pending <= expected_peaks.size();
			peaks_checked <= peak_cnt;
		end
	end

endmodule
`default_nettype wire

/* bench/region_peak_finder_top_test.sv */
// region_peak_finder_top_test: stimulus, flow control and verdict for the region peak finder
`default_nettype none
module region_peak_finder_top_test;
	import rpf_pkg::*;

	localparam int IDLE_PCT     = 38;
	localparam int HOLD_CYCLES  = 200;
	localparam int SETTLE       = 16;
	localparam int RANDOM_ITEMS = 300;
	localparam int LIMIT_TIME   = 6000000;

	typedef enum int {
		FILL_NOISE,
		FILL_DIM,
		FILL_FLAT,
		FILL_BRIGHT
	} fill_t;

	logic clk;
	logic arst_n;

	rpf_cfg_if   cfg();
	rpf_pixel_if pixel();
	rpf_peak_if  peak();

	int errors;
	int pending;
	int peaks_checked;

	// flow control knobs shared by the sender and the receiver
	bit steady;
	bit hold_peak;

	// stimulus bookkeeping
	int pixels_sent;
	int writes_done;
	int searches_cut;
	logic [DIM_W-1:0] cur_width;
	logic [DIM_W-1:0] cur_height;

	region_peak_finder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pixel  (pixel),
		.peak   (peak)
	);

	region_peak_finder_checker peak_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.pixel         (pixel),
		.peak          (peak),
		.errors        (errors),
		.pending       (pending),
		.peaks_checked (peaks_checked)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run limit
	initial begin
		#(LIMIT_TIME);
		$display("end of test: mismatches");
		$finish;
	end

	// peak receiver: random stalls, steady stretches, one long hold-off on request
	initial begin
		peak.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_peak) begin
				peak.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_peak = 1'b0;
			end else if (steady) begin
				peak.ready <= 1'b1;
			end else begin
				peak.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// pixels in the region under the current settings
	function automatic int region_pixels();
		int w;
		int h;
		w = (cur_width == '0) ? 1 : ((int'(cur_width) > MAX_DIM) ? MAX_DIM : int'(cur_width));
		h = (cur_height == '0) ? 1 : ((int'(cur_height) > MAX_DIM) ? MAX_DIM : int'(cur_height));
		return w * h;
	endfunction

	// mostly tiny extents, now and then a wider one
	function automatic logic [DIM_W-1:0] pick_extent();
		if ($urandom_range(9) == 0) begin
			return DIM_W'($urandom_range(40, 7));
		end
		return DIM_W'($urandom_range(6));
	endfunction

	// one pixel word, with random idle cycles ahead of it
	task automatic send_pixel(input logic [INT_BITS-1:0] red);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			pixel.valid <= 1'b0;
			@(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.pixel_red <= red;
		do @(posedge clk); while (!pixel.ready);
		pixels_sent++;
	endtask

	// a run of pixels of one flavor
	task automatic send_run(input int count, input fill_t fill);
		logic [INT_BITS-1:0] flat;
		logic [INT_BITS-1:0] red;
		flat = INT_BITS'($urandom);
		for (int i = 0; i < count; i++) begin
			case (fill)
				FILL_DIM: red = INT_BITS'($urandom_range(2));
				FILL_FLAT: red = flat;
				FILL_BRIGHT: red = INT_BITS'($urandom_range(255, 253));
				default: red = INT_BITS'($urandom);
			endcase
			send_pixel(red);
		end
	endtask

	// pause the pixel stream until every peak word is back and the pipe is empty
	task automatic settle();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one register write word
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		writes_done++;
		case (idx)
			REG_WIDTH: cur_width = data;
			REG_HEIGHT: cur_height = data;
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic program_region(input logic [CFG_DATA_W-1:0] left_v,
			input logic [CFG_DATA_W-1:0] top_v, input logic [CFG_DATA_W-1:0] width_v,
			input logic [CFG_DATA_W-1:0] height_v);
		write_reg(REG_LEFT, left_v);
		write_reg(REG_TOP, top_v);
		write_reg(REG_WIDTH, width_v);
		write_reg(REG_HEIGHT, height_v);
	endtask

	// stimulus
	initial begin
		int random_start;
		int bursts;
		int n;
		int cut;
		fill_t fill;

		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pixel.valid = 1'b0;
		pixel.pixel_red = '0;
		steady = 1'b0;
		hold_peak = 1'b0;
		pixels_sent = 0;
		writes_done = 0;
		searches_cut = 0;
		cur_width = DIM_W'(1);
		cur_height = DIM_W'(1);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every pixel is a one-pixel region
		send_pixel(8'd0);
		send_pixel(8'd255);
		settle();

		// zero extents at the far corner, upper data bits of left and top dropped
		program_region(13'h1FFF, 13'h1FFF, 13'd0, 13'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		settle();

		// flat 3x3: the centre pixel wins the intensity tie
		program_region(13'd0, 13'd0, 13'd3, 13'd3);
		send_run(9, FILL_FLAT);
		settle();

		// equal intensity and equal distance either side of centre: earlier one kept
		program_region(13'd100, 13'd200, 13'd3, 13'd1);
		send_pixel(8'd5);
		send_pixel(8'd0);
		send_pixel(8'd5);
		settle();

		// unknown register index mid-region leaves the search running
		program_region(13'd8, 13'd8, 13'd3, 13'd2);
		send_run(2, FILL_NOISE);
		settle();
		write_reg(8'hFF, 13'h1ABC);
		send_run(4, FILL_NOISE);
		settle();

		// known register write mid-region aborts and re-arms
		send_run(2, FILL_BRIGHT);
		settle();
		write_reg(REG_LEFT, 13'd20);
		searches_cut++;
		send_run(6, FILL_DIM);
		settle();

		// long output hold-off with one peak per pixel: the block backs up
		program_region(13'($urandom), 13'($urandom), 13'd1, 13'd1);
		steady = 1'b1;
		hold_peak = 1'b1;
		send_run(40, FILL_NOISE);
		steady = 1'b0;
		settle();

		// random regions, some broken off or interrupted by stray writes
		random_start = pixels_sent;
		while (pixels_sent - random_start < RANDOM_ITEMS) begin
			if ($urandom_range(3) == 0) begin
				write_reg(REG_WIDTH, pick_extent());
				write_reg(REG_HEIGHT, 13'($urandom_range(5)));
			end else begin
				program_region(13'($urandom), 13'($urandom), pick_extent(),
					13'($urandom_range(5)));
			end
			bursts = $urandom_range(3, 1);
			repeat (bursts) begin
				n = region_pixels();
				fill = fill_t'($urandom_range(3));
				if ($urandom_range(9) == 0) begin
					cut = $urandom_range(n - 1);
					send_run(cut, fill);
					settle();
					if ($urandom_range(1) == 0) begin
						write_reg(CFG_IDX_W'($urandom_range(255, 4)), 13'($urandom));
						send_run(n - cut, fill);
					end else begin
						n = $urandom_range(3);
						if (n >= 2) begin
							write_reg(CFG_IDX_W'(n), 13'($urandom_range(6)));
						end else begin
							write_reg(CFG_IDX_W'(n), 13'($urandom));
						end
						searches_cut++;
					end
				end else begin
					send_run(n, fill);
				end
			end
			settle();
		end

		// long stretch with no idling on either side
		steady = 1'b1;
		program_region(13'($urandom), 13'($urandom), 13'd5, 13'd4);
		send_run(120, FILL_NOISE);
		steady = 1'b0;
		settle();

		// saturated width, broken off early by a register write
		program_region(13'($urandom), 13'($urandom), 13'h1FFF, 13'd1);
		send_run(48, FILL_NOISE);
		settle();
		write_reg(REG_HEIGHT, 13'd1);
		searches_cut++;

		// saturated height with idling, mostly ties, broken off the same way
		program_region(13'($urandom), 13'($urandom), 13'd1, 13'd4097);
		send_run(48, FILL_DIM);
		settle();
		write_reg(REG_WIDTH, 13'd1);
		searches_cut++;

		$display("run covered %0d pixel words, %0d peak words, %0d register writes",
			pixels_sent, peaks_checked, writes_done);
		$display("regions from 1x1 to saturated extents, %0d searches aborted mid-region",
			searches_cut);
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
src/rpf_pkg.sv
src/rpf_if.sv
src/rpf_front.sv
src/rpf_fifo.sv
src/rpf_back.sv
src/region_peak_finder_top.sv
bench/region_peak_finder_checker.sv
bench/region_peak_finder_top_test.sv
